[hw/rtl/btpc_pkg.sv]
// Package for the barometric temperature and pressure compensation block.
// Holds widths, compensation constants and register indexes; no dependencies.
package btpc_pkg;

   typedef enum logic [1:0] {
      CSR_COEF_A = 2'd0,
      CSR_COEF_B = 2'd1,
      CSR_COEF_C = 2'd2,
      CSR_OSS    = 2'd3
   } csr_index_type;

   localparam int TEMP_DIV_NW  = 27;
   localparam int TEMP_DIV_DW  = 18;
   localparam int PRESS_DIV_NW = 32;
   localparam int PRESS_DIV_DW = 17;

   localparam logic signed [28:0] B6_OFFSET   = 29'sd4000;
   localparam logic signed [20:0] B4_BIAS     = 21'sd32768;
   localparam logic        [15:0] B7_SCALE    = 16'd50000;
   localparam logic signed [13:0] PC_SQ       = 14'sd3038;
   localparam logic signed [14:0] PC_LIN      = -15'sd7357;
   localparam logic signed [17:0] PC_OFS      = 18'sd3791;
   localparam logic signed [31:0] PRESS_MAX   = 32'sd131071;
   localparam logic signed [24:0] TEMP_MAX    = 25'sd32767;
   localparam logic signed [24:0] TEMP_MIN    = -25'sd32768;

endpackage

[hw/rtl/btpc_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word alongside; uses no package.
module btpc_div #(
   parameter int NW = 32,
   parameter int DW = 17,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [PW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [PW-1:0] out_side
);

   logic          vld_ff  [NW];
   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] nq_ff   [NW];
   logic [DW-1:0] den_ff  [NW];
   logic [PW-1:0] side_ff [NW];

   logic          vld_src  [NW];
   logic [DW-1:0] rem_src  [NW];
   logic [NW-1:0] nq_src   [NW];
   logic [DW-1:0] den_src  [NW];
   logic [PW-1:0] side_src [NW];
   logic [DW:0]   trial    [NW];
   logic [DW:0]   diff     [NW];
   logic [DW-1:0] rem_in   [NW];
   logic [NW-1:0] nq_in    [NW];

   genvar k;
   generate
      for (k = 0; k < NW; k++) begin : g_stage
         if (k == 0) begin : g_first
            assign vld_src[k]  = in_valid;
            assign rem_src[k]  = '0;
            assign nq_src[k]   = in_num;
            assign den_src[k]  = in_den;
            assign side_src[k] = in_side;
         end else begin : g_next
            assign vld_src[k]  = vld_ff[k-1];
            assign rem_src[k]  = rem_ff[k-1];
            assign nq_src[k]   = nq_ff[k-1];
            assign den_src[k]  = den_ff[k-1];
            assign side_src[k] = side_ff[k-1];
         end

         always_comb begin
            trial[k] = {rem_src[k], nq_src[k][NW-1]};
            diff[k]  = trial[k] - {1'b0, den_src[k]};
            if (trial[k] >= {1'b0, den_src[k]}) begin
               rem_in[k] = diff[k][DW-1:0];
               nq_in[k]  = {nq_src[k][NW-2:0], 1'b1};
            end else begin
               rem_in[k] = trial[k][DW-1:0];
               nq_in[k]  = {nq_src[k][NW-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_src[k];
            end
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   endgenerate

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = nq_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

[hw/rtl/baro_temp_pressure_compensate.sv]
// Top level of the barometric temperature and pressure compensation block.
// Depends on btpc_pkg and btpc_div.
//
//   channel   ports                                   handshake
//   request   start, busy, req_raw_temp, req_raw_press_bytes   start && !busy
//   response  rsp_valid, rsp_temp_tenths, rsp_press_pa, rsp_invalid  strobe
//   csr       csr_valid, csr_ready, csr_index, csr_wdata       valid && ready
//
// One transaction per cycle; busy is always low and csr_ready always high.
// Each result strobes after its request has passed 27 stages of the
// temperature divider, 32 of the pressure divider and 12 arithmetic stages.
// Synchronous reset clears valid bits and the CSR registers; no stall exists.
module baro_temp_pressure_compensate (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_raw_temp,
   input  logic [23:0]        req_raw_press_bytes,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_temp_tenths,
   output logic [16:0]        rsp_press_pa,
   output logic               rsp_invalid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int TNW = btpc_pkg::TEMP_DIV_NW;
   localparam int TDW = btpc_pkg::TEMP_DIV_DW;
   localparam int PNW = btpc_pkg::PRESS_DIV_NW;
   localparam int PDW = btpc_pkg::PRESS_DIV_DW;

   logic [63:0] coef_a_ff, coef_b_ff;
   logic [31:0] coef_c_ff;
   logic [1:0]  oss_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         oss_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (btpc_pkg::csr_index_type'(csr_index))
            btpc_pkg::CSR_COEF_A: coef_a_ff <= csr_wdata;
            btpc_pkg::CSR_COEF_B: coef_b_ff <= csr_wdata;
            btpc_pkg::CSR_COEF_C: coef_c_ff <= csr_wdata[31:0];
            btpc_pkg::CSR_OSS:    oss_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic        [15:0] ac4, ac5, ac6;
   assign ac1 = coef_a_ff[63:48];
   assign ac2 = coef_a_ff[47:32];
   assign ac3 = coef_a_ff[31:16];
   assign ac4 = coef_a_ff[15:0];
   assign ac5 = coef_b_ff[63:48];
   assign ac6 = coef_b_ff[47:32];
   assign b1  = coef_b_ff[31:16];
   assign b2  = coef_b_ff[15:0];
   assign mc  = coef_c_ff[31:16];
   assign md  = coef_c_ff[15:0];

   // stage 0: capture
   logic        p0_vld_ff;
   logic [15:0] p0_ut_ff;
   logic [18:0] p0_up_ff;
   logic [23:0] p0_up_in;
   assign p0_up_in = req_raw_press_bytes >> (4'd8 - {2'b00, oss_ff});

   // stage 1: x1 of temperature
   logic               p1_vld_ff;
   logic signed [16:0] p1_x1_ff;
   logic [18:0]        p1_up_ff;
   logic signed [16:0] p1_dut;
   logic signed [33:0] p1_prod;
   assign p1_dut  = $signed({1'b0, p0_ut_ff}) - $signed({1'b0, ac6});
   assign p1_prod = p1_dut * $signed({1'b0, ac5});

   // stage 2: divider operands
   logic               p2_vld_ff;
   logic [TNW-1:0]     p2_num_ff;
   logic [TDW-1:0]     p2_den_ff;
   logic [37:0]        p2_side_ff;
   logic signed [17:0] p2_d;
   logic signed [26:0] p2_n;
   logic [TNW-1:0]     p2_num_in;
   logic [TDW-1:0]     p2_den_in;
   assign p2_d      = 18'(p1_x1_ff) + 18'(md);
   assign p2_n      = {mc, 11'd0};
   assign p2_num_in = p2_n[26] ? TNW'(-p2_n) : TNW'(p2_n);
   assign p2_den_in = p2_d[17] ? TDW'(-p2_d) : TDW'(p2_d);

   logic           d1_vld;
   logic [TNW-1:0] d1_quo;
   logic [37:0]    d1_side;

   btpc_div #(.NW(TNW), .DW(TDW), .PW(38)) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p2_vld_ff),
      .in_num    (p2_num_ff),
      .in_den    (p2_den_ff),
      .in_side   (p2_side_ff),
      .out_valid (d1_vld),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // stage 3: b5, b6
   logic               p3_vld_ff, p3_zero_ff;
   logic signed [28:0] p3_b5_ff, p3_b6_ff;
   logic [18:0]        p3_up_ff;
   logic signed [27:0] p3_x2;
   logic signed [28:0] p3_b5_in;
   logic signed [16:0] d1_x1;
   assign d1_x1    = d1_side[16:0];
   assign p3_x2    = d1_side[37] ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
   assign p3_b5_in = 29'(d1_x1) + 29'(p3_x2);

   // stage 4: products of b6
   logic               p4_vld_ff, p4_zero_ff;
   logic signed [28:0] p4_b5_ff;
   logic [18:0]        p4_up_ff;
   logic signed [19:0] p4_sq_ff;
   logic signed [20:0] p4_a2_ff;
   logic signed [18:0] p4_a3_ff;
   logic signed [57:0] p4_sq;
   logic signed [44:0] p4_a2, p4_a3;
   assign p4_sq = p3_b6_ff * p3_b6_ff;
   assign p4_a2 = ac2 * p3_b6_ff;
   assign p4_a3 = ac3 * p3_b6_ff;

   // stage 5: b2 and b1 terms
   logic               p5_vld_ff, p5_zero_ff;
   logic signed [28:0] p5_b5_ff;
   logic [18:0]        p5_up_ff;
   logic signed [20:0] p5_a2_ff, p5_x1a_ff;
   logic signed [18:0] p5_a3_ff;
   logic signed [15:0] p5_x1b_ff;
   logic signed [35:0] p5_pb2, p5_pb1;
   assign p5_pb2 = b2 * p4_sq_ff;
   assign p5_pb1 = b1 * p4_sq_ff;

   // stage 6: b3 and b4 operand
   logic               p6_vld_ff, p6_zero_ff;
   logic signed [28:0] p6_b5_ff;
   logic [18:0]        p6_up_ff;
   logic signed [24:0] p6_b3_ff;
   logic signed [20:0] p6_u_ff;
   logic signed [21:0] p6_x3;
   logic signed [22:0] p6_s;
   logic signed [26:0] p6_sh;
   logic signed [20:0] p6_t;
   assign p6_x3 = 22'(p5_x1a_ff) + 22'(p5_a2_ff);
   assign p6_s  = 23'($signed({ac1, 2'b00})) + 23'(p6_x3);
   assign p6_sh = (27'(p6_s) <<< oss_ff) + 27'sd2;
   assign p6_t  = 21'(p5_a3_ff) + 21'(p5_x1b_ff) + 21'sd2;

   // stage 7: b4, b7
   logic               p7_vld_ff, p7_zero_ff;
   logic signed [28:0] p7_b5_ff;
   logic [16:0]        p7_b4_ff;
   logic [31:0]        p7_b7_ff;
   logic [47:0]        p7_pb4, p7_pb7;
   logic [31:0]        p7_dp;
   logic [15:0]        p7_scale;
   assign p7_pb4   = ac4 * $unsigned(32'(p6_u_ff));
   assign p7_dp    = 32'(p6_up_ff) - $unsigned(32'(p6_b3_ff));
   assign p7_scale = btpc_pkg::B7_SCALE >> oss_ff;
   assign p7_pb7   = p7_dp * p7_scale;

   // stage 8: pressure divider operands
   logic           p8_vld_ff;
   logic [PNW-1:0] p8_num_ff;
   logic [PDW-1:0] p8_den_ff;
   logic [30:0]    p8_side_ff;

   logic           d2_vld;
   logic [PNW-1:0] d2_quo;
   logic [30:0]    d2_side;

   btpc_div #(.NW(PNW), .DW(PDW), .PW(31)) u_div_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p8_vld_ff),
      .in_num    (p8_num_ff),
      .in_den    (p8_den_ff),
      .in_side   (p8_side_ff),
      .out_valid (d2_vld),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   // stage 9: correction products
   logic               p9_vld_ff, p9_inv_ff;
   logic signed [28:0] p9_b5_ff;
   logic signed [31:0] p9_p_ff, p9_x1_ff;
   logic signed [15:0] p9_x2_ff;
   logic signed [31:0] p9_p_in;
   logic signed [23:0] p9_pa;
   logic signed [47:0] p9_sq;
   logic signed [46:0] p9_lin;
   assign p9_p_in = d2_side[29] ? {d2_quo[30:0], 1'b0} : d2_quo;
   assign p9_pa   = p9_p_in[31:8];
   assign p9_sq   = p9_pa * p9_pa;
   assign p9_lin  = btpc_pkg::PC_LIN * p9_p_in;

   // stage 10
   logic               p10_vld_ff, p10_inv_ff;
   logic signed [28:0] p10_b5_ff;
   logic signed [31:0] p10_p_ff;
   logic signed [15:0] p10_x1_ff, p10_x2_ff;
   logic signed [45:0] p10_prod;
   assign p10_prod = p9_x1_ff * btpc_pkg::PC_SQ;

   // stage 11: final sum, saturation
   logic signed [17:0] p11_sum;
   logic signed [31:0] p11_p;
   logic signed [28:0] p11_tb;
   logic signed [24:0] p11_t;
   logic signed [15:0] temp_in;
   logic [16:0]        press_in;
   always_comb begin
      p11_sum = 18'(p10_x1_ff) + 18'(p10_x2_ff) + btpc_pkg::PC_OFS;
      p11_p   = p10_p_ff + 32'($signed(p11_sum[17:4]));
      p11_tb  = p10_b5_ff + 29'sd8;
      p11_t   = p11_tb[28:4];
      if (p11_t > btpc_pkg::TEMP_MAX) begin
         temp_in = 16'sh7FFF;
      end else if (p11_t < btpc_pkg::TEMP_MIN) begin
         temp_in = -16'sh8000;
      end else begin
         temp_in = p11_t[15:0];
      end
      if (p11_p < 32'sd0) begin
         press_in = '0;
      end else if (p11_p > btpc_pkg::PRESS_MAX) begin
         press_in = 17'h1FFFF;
      end else begin
         press_in = p11_p[16:0];
      end
      if (p10_inv_ff) begin
         temp_in  = '0;
         press_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         p5_vld_ff  <= 1'b0;
         p6_vld_ff  <= 1'b0;
         p7_vld_ff  <= 1'b0;
         p8_vld_ff  <= 1'b0;
         p9_vld_ff  <= 1'b0;
         p10_vld_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         p0_vld_ff  <= start && !busy;
         p1_vld_ff  <= p0_vld_ff;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= d1_vld;
         p4_vld_ff  <= p3_vld_ff;
         p5_vld_ff  <= p4_vld_ff;
         p6_vld_ff  <= p5_vld_ff;
         p7_vld_ff  <= p6_vld_ff;
         p8_vld_ff  <= p7_vld_ff;
         p9_vld_ff  <= d2_vld;
         p10_vld_ff <= p9_vld_ff;
         rsp_valid  <= p10_vld_ff;
      end

      p0_ut_ff <= req_raw_temp;
      p0_up_ff <= p0_up_in[18:0];

      p1_x1_ff <= p1_prod[31:15];
      p1_up_ff <= p0_up_ff;

      p2_num_ff  <= p2_num_in;
      p2_den_ff  <= p2_den_in;
      p2_side_ff <= {mc[15] ^ p2_d[17], p2_d == 18'sd0, p1_up_ff, p1_x1_ff};

      p3_zero_ff <= d1_side[36];
      p3_up_ff   <= d1_side[35:17];
      p3_b5_ff   <= p3_b5_in;
      p3_b6_ff   <= p3_b5_in - btpc_pkg::B6_OFFSET;

      p4_zero_ff <= p3_zero_ff;
      p4_up_ff   <= p3_up_ff;
      p4_b5_ff   <= p3_b5_ff;
      p4_sq_ff   <= p4_sq[31:12];
      p4_a2_ff   <= p4_a2[31:11];
      p4_a3_ff   <= p4_a3[31:13];

      p5_zero_ff <= p4_zero_ff;
      p5_up_ff   <= p4_up_ff;
      p5_b5_ff   <= p4_b5_ff;
      p5_a2_ff   <= p4_a2_ff;
      p5_a3_ff   <= p4_a3_ff;
      p5_x1a_ff  <= p5_pb2[31:11];
      p5_x1b_ff  <= p5_pb1[31:16];

      p6_zero_ff <= p5_zero_ff;
      p6_up_ff   <= p5_up_ff;
      p6_b5_ff   <= p5_b5_ff;
      p6_b3_ff   <= p6_sh[26:2];
      p6_u_ff    <= 21'($signed(p6_t[20:2])) + btpc_pkg::B4_BIAS;

      p7_zero_ff <= p6_zero_ff;
      p7_b5_ff   <= p6_b5_ff;
      p7_b4_ff   <= p7_pb4[31:15];
      p7_b7_ff   <= p7_pb7[31:0];

      p8_num_ff  <= p7_b7_ff[31] ? p7_b7_ff : {p7_b7_ff[30:0], 1'b0};
      p8_den_ff  <= p7_b4_ff;
      p8_side_ff <= {p7_zero_ff || (p7_b4_ff == '0), p7_b7_ff[31], p7_b5_ff};

      p9_inv_ff <= d2_side[30];
      p9_b5_ff  <= d2_side[28:0];
      p9_p_ff   <= p9_p_in;
      p9_x1_ff  <= p9_sq[31:0];
      p9_x2_ff  <= p9_lin[31:16];

      p10_inv_ff <= p9_inv_ff;
      p10_b5_ff  <= p9_b5_ff;
      p10_p_ff   <= p9_p_ff;
      p10_x1_ff  <= p10_prod[31:16];
      p10_x2_ff  <= p9_x2_ff;

      rsp_temp_tenths <= temp_in;
      rsp_press_pa    <= press_in;
      rsp_invalid     <= p10_inv_ff;
   end

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_temp_tenths == 16'sd0 && rsp_press_pa == 17'd0)
      else $error("invalid result with non-zero fields");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid && !p10_vld_ff)
      else $error("valid survives reset");

   a_div_order : assert property (@(posedge clock) disable iff (reset)
      d2_vld |-> $past(p8_vld_ff, PNW))
      else $error("pressure divider output without matching input");

   a_div_temp_order : assert property (@(posedge clock) disable iff (reset)
      d1_vld |-> $past(p2_vld_ff, TNW))
      else $error("temperature divider output without matching input");

endmodule
